// File: rtl/onip_pkg.sv
// Shared types and constants for the octal nibble integer packer.
// Used by onip_ctrl, onip_dpath and the top level; no dependencies.
package onip_pkg;

	localparam int VAL_W          = 32;  // width of the value port
	localparam int OP_W           = 2;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [3:0] END_FLAG = 4'h8;

	typedef enum logic [OP_W-1:0] {
		OP_INT   = 2'd0,
		OP_NIB   = 2'd1,
		OP_ALIGN = 2'd2,
		OP_BYTE  = 2'd3
	} op_t;

	// datapath commands issued by the controller
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_INT_LOAD,
		CMD_INT_PEND,
		CMD_NIB,
		CMD_ALIGN,
		CMD_BYTE_LOAD,
		CMD_BYTE_OUT,
		CMD_INT_STEP
	} dp_cmd_t;

	typedef struct packed {
		logic half;       // a high nibble is pending
		logic digits_one; // input integer has a single octal digit
		logic rem_last;   // current integer step emits the final byte
		logic out_free;   // output register can take a byte this cycle
	} dp_stat_t;

endpackage

// File: rtl/onip_ctrl.sv
// Controller for the octal nibble integer packer: sequences items into
// datapath commands. Depends on onip_pkg.
module onip_ctrl
	import onip_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [OP_W-1:0] operation,
	input  dp_stat_t        stat,
	output dp_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INT,
		ST_BYTE
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    op;

	assign op       = op_t'(operation);
	assign in_ready = (state_q == ST_IDLE) && stat.out_free;

	always_comb begin
		cmd     = CMD_NONE;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					case (op)
						OP_INT: begin
							// single digit into an empty half byte completes nothing
							if (!stat.half && stat.digits_one) begin
								cmd = CMD_INT_PEND;
							end else begin
								cmd     = CMD_INT_LOAD;
								state_d = ST_INT;
							end
						end
						OP_NIB:   cmd = CMD_NIB;
						OP_ALIGN: cmd = CMD_ALIGN;
						OP_BYTE: begin
							cmd = CMD_BYTE_LOAD;
							if (stat.half) begin
								state_d = ST_BYTE;
							end
						end
						default: cmd = CMD_NONE;
					endcase
				end
			end
			ST_INT: begin
				if (stat.out_free) begin
					cmd = CMD_INT_STEP;
					if (stat.rem_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_BYTE: begin
				if (stat.out_free) begin
					cmd     = CMD_BYTE_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/onip_dpath.sv
// Datapath for the octal nibble integer packer: pending half byte, digit
// counter, operand register and output register. Depends on onip_pkg.
module onip_dpath
	import onip_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last
);

	localparam int IW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W; // integer bits used
	localparam int ND = (IW + 2) / 3;                             // octal digits
	localparam int PW = 3 * ND;
	localparam int CW = $clog2(ND + 1);

	logic [IW-1:0] val_q;
	logic [CW-1:0] cnt_q;
	logic          half_q;
	logic [3:0]    pend_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;

	logic [CW-1:0] cnt_d;
	logic          half_d;
	logic [3:0]    pend_d;
	logic          emit;
	logic [7:0]    nb;
	logic          nl;

	logic [PW-1:0] val_pad;
	logic [3:0]    dig_hi;
	logic [3:0]    dig_lo;
	logic [3:0]    dig0;
	logic [CW-1:0] nc;
	logic [7:0]    step_byte;

	function automatic logic [3:0] get_digit(input logic [PW-1:0] v,
		input logic [CW-1:0] idx);
		logic [3:0] d;
		d = '0;
		for (int j = 0; j < ND; j++) begin
			if (idx == CW'(j)) begin
				d = (j == 0) ? (4'(v[3*j +: 3]) | END_FLAG) : 4'(v[3*j +: 3]);
			end
		end
		return d;
	endfunction

	// number of octal digits without leading zeros, at least one
	function automatic logic [CW-1:0] count_digits(input logic [PW-1:0] v);
		logic [CW-1:0] n;
		n = CW'(1);
		for (int j = 0; j < ND; j++) begin
			if (v[3*j +: 3] != 3'd0) begin
				n = CW'(j + 1);
			end
		end
		return n;
	endfunction

	assign val_pad   = PW'(val_q);
	assign dig_hi    = get_digit(val_pad, cnt_q - CW'(1));
	assign dig_lo    = get_digit(val_pad, cnt_q - CW'(2));
	assign dig0      = 4'(val_q[2:0]) | END_FLAG;
	assign nc        = half_q ? (cnt_q - CW'(1)) : (cnt_q - CW'(2));
	assign step_byte = half_q ? {pend_q, dig_hi} : {dig_hi, dig_lo};

	assign stat.half       = half_q;
	assign stat.digits_one = (value[IW-1:3] == '0);
	assign stat.rem_last   = (nc <= CW'(1));
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		cnt_d  = cnt_q;
		half_d = half_q;
		pend_d = pend_q;
		emit   = 1'b0;
		nb     = step_byte;
		nl     = 1'b0;
		case (cmd)
			CMD_NONE: begin
			end
			CMD_INT_LOAD: cnt_d = count_digits(PW'(value[IW-1:0]));
			CMD_INT_PEND: begin
				pend_d = 4'(value[2:0]) | END_FLAG;
				half_d = 1'b1;
			end
			CMD_NIB: begin
				if (half_q) begin
					emit   = 1'b1;
					nb     = {pend_q, value[3:0]};
					nl     = 1'b1;
					half_d = 1'b0;
					pend_d = '0;
				end else begin
					pend_d = value[3:0];
					half_d = 1'b1;
				end
			end
			CMD_ALIGN: begin
				if (half_q) begin
					emit   = 1'b1;
					nb     = {pend_q, 4'h0};
					nl     = 1'b1;
					half_d = 1'b0;
					pend_d = '0;
				end
			end
			CMD_BYTE_LOAD: begin
				emit = 1'b1;
				if (half_q) begin
					nb     = {pend_q, 4'h0};
					half_d = 1'b0;
					pend_d = '0;
				end else begin
					nb = value[7:0];
					nl = 1'b1;
				end
			end
			CMD_BYTE_OUT: begin
				emit = 1'b1;
				nb   = val_q[7:0];
				nl   = 1'b1;
			end
			CMD_INT_STEP: begin
				emit = 1'b1;
				nl   = (nc <= CW'(1));
				// a lone final digit stays behind as the pending high nibble
				if (nc == CW'(1)) begin
					pend_d = dig0;
					half_d = 1'b1;
					cnt_d  = '0;
				end else begin
					pend_d = '0;
					half_d = 1'b0;
					cnt_d  = nc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			half_q      <= 1'b0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			half_q <= half_d;
			pend_q <= pend_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_INT_LOAD || cmd == CMD_BYTE_LOAD) begin
			val_q <= value[IW-1:0];
		end
		if (emit) begin
			out_byte_q <= nb;
			last_q     <= nl;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

// File: rtl/octal_nibble_integer_packer_core.sv
// Octal nibble integer packer, top level.
// Input channel (in_valid/in_ready): operation and value. Operations are
// write integer (octal digits, most significant first, end flag on the
// last digit), write raw nibble, align flush and write raw byte.
// Output channel (out_valid/out_ready): completed bytes, first nibble in the
// high half; last marks the final byte caused by an item. An item that
// completes no byte produces nothing on the output channel.
// Items are handled one at a time. The datapath forms one byte per cycle
// while the output register is free: an integer item is loaded and then
// gives one byte per step (up to 6 with the default VALUE_BITS), a raw
// byte after a pending nibble gives the padded nibble and then the byte.
// Bytes leave through the single output byte register, which sets the rate.
// in_ready is high only while the controller is idle and the output
// register is empty or being read. When the receiver stalls, emission
// holds and the current byte stays valid and unchanged.
// Reset clears the pending half byte and any byte in flight.
// Depends on onip_pkg, onip_ctrl and onip_dpath.
module octal_nibble_integer_packer_core
	import onip_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [OP_W-1:0]  operation,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	onip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd)
	);

	onip_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
